FILE: src/rdp_pkg.sv
// Package for the RGB888 to RGB565 dither packer.
// Pixel type, reset constants, the xorshift step and the per-pixel conversions.
// No dependencies.
package rdp_pkg;

  localparam int unsigned PIX_PER_GRP = 4;
  localparam logic [31:0] NOISE_SEED  = 32'h1234_5678;
  localparam logic        DITHER_RST  = 1'b1;

  // red sits in bits 7:0, so it is the last member
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pix_t;

  typedef logic [15:0] rgb565_t;

  function automatic logic [31:0] xorshift_step(input logic [31:0] s);
    logic [31:0] t;
    t = s ^ (s << 13);
    t = t ^ (t >> 17);
    t = t ^ (t << 5);
    return t;
  endfunction

  function automatic rgb565_t to565(input pix_t p);
    return {p.red[7:3], p.green[7:2], p.blue[7:3]};
  endfunction

  // noise is the generator word already shifted for this pixel
  function automatic rgb565_t dither_px(input pix_t p, input logic [31:0] noise);
    pix_t q;
    q.red   = p.red   - {5'd0, p.red[7:5]}   + {5'd0, noise[2:0]};
    q.green = p.green - {6'd0, p.green[7:6]} + {6'd0, noise[9:8]};
    q.blue  = p.blue  - {5'd0, p.blue[7:5]}  + {5'd0, noise[18:16]};
    return to565(q);
  endfunction

endpackage

FILE: src/rdp_if.sv
// Channel interfaces for the dither packer: pixel group requests in, packed words out.
// Depends on rdp_pkg.
interface rdp_in_if
  import rdp_pkg::*;
  ();
  logic valid;
  logic ready;
  pix_t pixel_a;
  pix_t pixel_b;
  pix_t pixel_c;
  pix_t pixel_d;
  logic group_last;

  modport source (output valid, pixel_a, pixel_b, pixel_c, pixel_d, group_last, input ready);
  modport sink   (input valid, pixel_a, pixel_b, pixel_c, pixel_d, group_last, output ready);
endinterface

interface rdp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] word_first;
  logic [31:0] word_second;
  logic        band_end;

  modport source (output valid, word_first, word_second, band_end, input ready);
  modport sink   (input valid, word_first, word_second, band_end, output ready);
endinterface

FILE: src/rdp_noise.sv
// Xorshift32 noise generator, stepped once per dithered pixel group.
// Depends on rdp_pkg.
module rdp_noise
  import rdp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step_en,
  output logic [31:0] noise_nxt
);

  logic [31:0] noise_r;

  assign noise_nxt = xorshift_step(noise_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      noise_r <= NOISE_SEED;
    end else if (step_en) begin
      noise_r <= noise_nxt;
    end
  end

endmodule

FILE: src/rdp_pack.sv
// Converts four RGB888 pixels to RGB565, with or without noise, and packs two per word.
// Depends on rdp_pkg.
module rdp_pack
  import rdp_pkg::*;
(
  input  pix_t        pix [PIX_PER_GRP],
  input  logic [31:0] noise,
  input  logic        dither_en,
  output logic [31:0] word_first,
  output logic [31:0] word_second
);

  rgb565_t px565 [PIX_PER_GRP];

  for (genvar k = 0; k < PIX_PER_GRP; k++) begin : g_px
    // pixel k takes the generator word shifted down by two bits per pixel
    logic [31:0] noise_k;
    assign noise_k  = noise >> (2 * k);
    assign px565[k] = dither_en ? dither_px(pix[k], noise_k) : to565(pix[k]);
  end

  assign word_first  = {px565[0], px565[1]};
  assign word_second = {px565[2], px565[3]};

endmodule

FILE: src/rgb888_to_rgb565_dither_packer.sv
// Top level of the RGB888 to RGB565 dither packer: input register, converter, result register.
// Depends on rdp_pkg, rdp_if, rdp_noise and rdp_pack.
//
//  channel   dir  handshake     payload
//  in_chan   in   valid/ready   pixel_a..pixel_d (24b each), group_last
//  out_chan  out  valid/ready   word_first, word_second (32b each), band_end
//  cfg_*     in   cfg_we        cfg_wdata: dither_enable
//
// One group per clock unless the result stalls; input register, then result register.
// The generator steps as a group moves into the result register.
// Synchronous reset clears both valid flags, sets dither on and reloads the noise seed.
// A stalled result holds while one more group can still be taken into the input register.
module rgb888_to_rgb565_dither_packer
  import rdp_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  cfg_we,
  input  logic  cfg_wdata,
  rdp_in_if.sink    in_chan,
  rdp_out_if.source out_chan
);

  logic        dither_en_r;
  logic        s1_valid_r;
  pix_t        s1_pix_r [PIX_PER_GRP];
  logic        s1_last_r;
  logic        out_valid_r;
  logic [31:0] out_first_r;
  logic [31:0] out_second_r;
  logic        out_last_r;

  logic        advance;
  logic [31:0] noise_nxt;
  logic [31:0] word_first;
  logic [31:0] word_second;

  assign advance       = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dither_en_r <= DITHER_RST;
    end else if (cfg_we) begin
      dither_en_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      s1_pix_r[0] <= in_chan.pixel_a;
      s1_pix_r[1] <= in_chan.pixel_b;
      s1_pix_r[2] <= in_chan.pixel_c;
      s1_pix_r[3] <= in_chan.pixel_d;
      s1_last_r   <= in_chan.group_last;
    end
  end

  rdp_noise u_noise (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (advance && dither_en_r),
    .noise_nxt (noise_nxt)
  );

  rdp_pack u_pack (
    .pix         (s1_pix_r),
    .noise       (noise_nxt),
    .dither_en   (dither_en_r),
    .word_first  (word_first),
    .word_second (word_second)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_chan.ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_first_r  <= word_first;
      out_second_r <= word_second;
      out_last_r   <= s1_last_r;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.word_first  = out_first_r;
  assign out_chan.word_second = out_second_r;
  assign out_chan.band_end    = out_last_r;

endmodule

FILE: src/rdp_checker.sv
// Port-level checks for the dither packer, attached to the top level by bind.
// No package dependency.
module rdp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_word_first,
  input logic [31:0] out_word_second,
  input logic        out_band_end
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result request dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_word_first) && $stable(out_word_second)
                                && $stable(out_band_end))
    else $error("stalled result changed");

  a_rst_clear: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // with the result register empty the input side can never be blocked
  a_no_block: assert property (@(posedge clk) !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

endmodule

bind rgb888_to_rgb565_dither_packer rdp_checker u_rdp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_chan.ready),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_word_first  (out_chan.word_first),
  .out_word_second (out_chan.word_second),
  .out_band_end    (out_chan.band_end)
);
